// ===== rtl/cmig_pkg.sv =====
`default_nettype none

package cmig_pkg;

  // default limits, handed to the top level parameters
  localparam int unsigned MAX_STACKS_DEF = 4096;
  localparam int unsigned MAX_SLICES_DEF = 256;
  localparam int unsigned MAX_LAYERS_DEF = 64;

  // field and register widths
  localparam int unsigned SC_W   = 9;   // slice_count register
  localparam int unsigned LC_W   = 7;   // layer_count register
  localparam int unsigned STK_W  = 13;  // stack_index
  localparam int unsigned SLC_W  = 9;   // slice_index
  localparam int unsigned IDX_W  = 27;  // vertex index
  localparam int unsigned PS_W   = 16;  // vertices per stack, s*l+1
  localparam int unsigned OFS_W  = 16;  // ring offset inside a stack, j*l
  localparam int unsigned CNT_W  = 6;   // cell counter inside a column
  localparam int unsigned CFG_W  = 9;   // config write data
  localparam int unsigned CFGA_W = 1;   // config register index

  // config register indexes
  localparam logic [CFGA_W-1:0] CFG_SLICE_COUNT = 1'd0;
  localparam logic [CFGA_W-1:0] CFG_LAYER_COUNT = 1'd1;

  localparam logic [SC_W-1:0] SLICE_COUNT_RST = 9'd20;
  localparam logic [LC_W-1:0] LAYER_COUNT_RST = 7'd6;

  // cell kinds
  localparam logic CELL_PRISM = 1'b0;
  localparam logic CELL_HEX   = 1'b1;

  // after range check: k-1, j-1, wrapped next slice, vertices per stack
  typedef struct packed {
    logic [STK_W-1:0] km1;
    logic [SLC_W-1:0] jm1;
    logic [SLC_W-1:0] jnx;
    logic [PS_W-1:0]  per_stack;
    logic [LC_W-1:0]  lc;
  } setup_t;

  // after the multipliers
  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [OFS_W-1:0] ofs_a;
    logic [OFS_W-1:0] ofs_b;
    logic [PS_W-1:0]  per_stack;
    logic [LC_W-1:0]  lc;
  } prod_t;

  // first adder stage
  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] lo_a;
    logic [IDX_W-1:0] lo_b;
    logic [PS_W-1:0]  per_stack;
    logic [LC_W-1:0]  lc;
  } part_t;

  // complete column bases for the emitter
  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] lo_a;
    logic [IDX_W-1:0] lo_b;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] hi_a;
    logic [IDX_W-1:0] hi_b;
    logic [LC_W-1:0]  lc;
  } col_t;

  // one cell
  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    logic [IDX_W-1:0] cc;
    logic [IDX_W-1:0] cd;
    logic [IDX_W-1:0] ce;
    logic [IDX_W-1:0] cf;
    logic [IDX_W-1:0] cg;
    logic [IDX_W-1:0] ch;
    logic             last;
  } cell_t;

endpackage

`default_nettype wire

// ===== rtl/cmig_setup.sv =====
`default_nettype none

module cmig_setup #(
  parameter int unsigned MAX_STACKS = cmig_pkg::MAX_STACKS_DEF,
  parameter int unsigned MAX_SLICES = cmig_pkg::MAX_SLICES_DEF,
  parameter int unsigned MAX_LAYERS = cmig_pkg::MAX_LAYERS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [cmig_pkg::SC_W-1:0]    slice_count_i,
  input  wire logic [cmig_pkg::LC_W-1:0]    layer_count_i,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [cmig_pkg::STK_W-1:0]   stack_index_i,
  input  wire logic [cmig_pkg::SLC_W-1:0]   slice_index_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output cmig_pkg::setup_t                  data_o
);

  logic [cmig_pkg::SC_W-1:0] s_eff;
  logic [cmig_pkg::LC_W-1:0] l_eff;
  logic                      in_range;
  logic                      v_q;
  cmig_pkg::setup_t          d_d, d_q;

  // clamp the config to its legal range
  always_comb begin
    priority if (slice_count_i == '0) begin
      s_eff = cmig_pkg::SC_W'(1);
    end else if (32'(slice_count_i) > MAX_SLICES) begin
      s_eff = cmig_pkg::SC_W'(MAX_SLICES);
    end else begin
      s_eff = slice_count_i;
    end
    priority if (layer_count_i == '0) begin
      l_eff = cmig_pkg::LC_W'(1);
    end else if (32'(layer_count_i) > MAX_LAYERS) begin
      l_eff = cmig_pkg::LC_W'(MAX_LAYERS);
    end else begin
      l_eff = layer_count_i;
    end
  end

  assign in_range = (stack_index_i != '0) && (32'(stack_index_i) <= MAX_STACKS) &&
                    (slice_index_i != '0) && (slice_index_i <= s_eff);

  always_comb begin
    d_d.km1       = stack_index_i - cmig_pkg::STK_W'(1);
    d_d.jm1       = slice_index_i - cmig_pkg::SLC_W'(1);
    d_d.jnx       = (slice_index_i == s_eff) ? '0 : slice_index_i;
    d_d.per_stack = cmig_pkg::PS_W'(s_eff) * cmig_pkg::PS_W'(l_eff)
                    + cmig_pkg::PS_W'(1);
    d_d.lc        = l_eff;
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i && in_range;  // out-of-range columns are dropped here
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

`default_nettype wire

// ===== rtl/cmig_mul.sv =====
`default_nettype none

module cmig_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cmig_pkg::setup_t  data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output cmig_pkg::prod_t        data_o
);

  localparam int unsigned LO_W = cmig_pkg::STK_W + cmig_pkg::PS_W;

  logic [LO_W-1:0]      lo_full;
  logic                 v_q;
  cmig_pkg::prod_t      d_d, d_q;

  // stack base (k-1)*V, kept modulo the index width
  assign lo_full = LO_W'(data_i.km1) * LO_W'(data_i.per_stack);

  always_comb begin
    d_d.lo        = lo_full[cmig_pkg::IDX_W-1:0];
    d_d.ofs_a     = cmig_pkg::OFS_W'(data_i.jm1) * cmig_pkg::OFS_W'(data_i.lc);
    d_d.ofs_b     = cmig_pkg::OFS_W'(data_i.jnx) * cmig_pkg::OFS_W'(data_i.lc);
    d_d.per_stack = data_i.per_stack;
    d_d.lc        = data_i.lc;
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

`default_nettype wire

// ===== rtl/cmig_sum.sv =====
`default_nettype none

module cmig_sum (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cmig_pkg::prod_t   data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output cmig_pkg::col_t         data_o
);

  logic              v1_q, v2_q;
  logic              rdy1, rdy2;
  cmig_pkg::part_t   p_d, p_q;
  cmig_pkg::col_t    c_d, c_q;

  // first add stage: lower ring bases lo+a+1, lo+b+1
  always_comb begin
    p_d.lo        = data_i.lo;
    p_d.lo_a      = data_i.lo + cmig_pkg::IDX_W'(data_i.ofs_a) + cmig_pkg::IDX_W'(1);
    p_d.lo_b      = data_i.lo + cmig_pkg::IDX_W'(data_i.ofs_b) + cmig_pkg::IDX_W'(1);
    p_d.per_stack = data_i.per_stack;
    p_d.lc        = data_i.lc;
  end

  // second add stage: the upper stack is one stack further
  always_comb begin
    c_d.lo   = p_q.lo;
    c_d.lo_a = p_q.lo_a;
    c_d.lo_b = p_q.lo_b;
    c_d.hi   = p_q.lo   + cmig_pkg::IDX_W'(p_q.per_stack);
    c_d.hi_a = p_q.lo_a + cmig_pkg::IDX_W'(p_q.per_stack);
    c_d.hi_b = p_q.lo_b + cmig_pkg::IDX_W'(p_q.per_stack);
    c_d.lc   = p_q.lc;
  end

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      p_q <= p_d;
    end
    if (rdy2 && v1_q) begin
      c_q <= c_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = c_q;

endmodule

`default_nettype wire

// ===== rtl/cmig_emit.sv =====
`default_nettype none

module cmig_emit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cmig_pkg::col_t    data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output cmig_pkg::cell_t        cell_o
);

  logic                        item_v_q;
  cmig_pkg::col_t              col_q;
  logic [cmig_pkg::IDX_W-1:0]  ra_q, rb_q, rc_q, rd_q;   // running corners, layer i-1
  logic [cmig_pkg::CNT_W-1:0]  cnt_q;
  logic                        out_v_q;
  cmig_pkg::cell_t             out_q, cell_d;
  logic                        out_free, fire, last, load;

  assign out_free = !out_v_q || ready_i;
  assign fire     = item_v_q && out_free;
  assign last     = (cmig_pkg::LC_W'(cnt_q) == (col_q.lc - cmig_pkg::LC_W'(1)));
  assign load     = !item_v_q || (fire && last);
  assign ready_o  = load;

  always_comb begin
    cell_d.last = last;
    if (cnt_q == '0) begin
      cell_d.kind = cmig_pkg::CELL_PRISM;
      cell_d.ca   = col_q.lo;
      cell_d.cb   = col_q.lo_a;
      cell_d.cc   = col_q.lo_b;
      cell_d.cd   = col_q.hi;
      cell_d.ce   = col_q.hi_a;
      cell_d.cf   = col_q.hi_b;
      cell_d.cg   = '0;
      cell_d.ch   = '0;
    end else begin
      cell_d.kind = cmig_pkg::CELL_HEX;
      cell_d.ca   = ra_q;
      cell_d.cb   = ra_q + cmig_pkg::IDX_W'(1);
      cell_d.cc   = rb_q + cmig_pkg::IDX_W'(1);
      cell_d.cd   = rb_q;
      cell_d.ce   = rc_q;
      cell_d.cf   = rc_q + cmig_pkg::IDX_W'(1);
      cell_d.cg   = rd_q + cmig_pkg::IDX_W'(1);
      cell_d.ch   = rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (load) begin
        item_v_q <= valid_i;
        cnt_q    <= '0;
      end else if (fire) begin
        cnt_q <= cnt_q + cmig_pkg::CNT_W'(1);
      end
      if (fire) begin
        out_v_q <= 1'b1;
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= cell_d;
    end
    if (load && valid_i) begin
      col_q <= data_i;
      ra_q  <= data_i.lo_a;
      rb_q  <= data_i.lo_b;
      rc_q  <= data_i.hi_a;
      rd_q  <= data_i.hi_b;
    end else if (fire && (cnt_q != '0)) begin
      ra_q <= ra_q + cmig_pkg::IDX_W'(1);
      rb_q <= rb_q + cmig_pkg::IDX_W'(1);
      rc_q <= rc_q + cmig_pkg::IDX_W'(1);
      rd_q <= rd_q + cmig_pkg::IDX_W'(1);
    end
  end

  assign valid_o = out_v_q;
  assign cell_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/cylinder_mesh_cell_index_gen_core.sv =====
`default_nettype none

// Cell connectivity generator for a structured cylindrical mesh. Each input
// transfer names one column (stack_index k from one, slice_index j from one to
// the slice count); the block answers with one centre prism (corner_g/h zero)
// followed by one hexahedron per adjacent pair of radial layers, last_cell set
// on the final cell. Vertex numbering per stack is a centre vertex and then
// slice-major, layer-minor ring vertices; the last slice wraps to slice zero.
// Columns with k or j out of range produce no cells. Slice and layer counts
// are clamped to one..MAX and should only be written while no column is in
// flight. Flow: a column passes a four-register front end (range check,
// multipliers, two adder stages), then the emitter's column register and
// the cell output register; the cell emitter issues one cell per cycle
// while the output is ready, layer_count cells (clamped) per column. The
// front end takes a new column every cycle while it has room and keeps up
// to four columns queued behind the emitter.
module cylinder_mesh_cell_index_gen_core #(
  parameter int unsigned MAX_STACKS = cmig_pkg::MAX_STACKS_DEF,
  parameter int unsigned MAX_SLICES = cmig_pkg::MAX_SLICES_DEF,
  parameter int unsigned MAX_LAYERS = cmig_pkg::MAX_LAYERS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [cmig_pkg::CFGA_W-1:0]   cfg_index_i,
  input  wire logic [cmig_pkg::CFG_W-1:0]    cfg_data_i,
  // column input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [cmig_pkg::STK_W-1:0]    stack_index_i,
  input  wire logic [cmig_pkg::SLC_W-1:0]    slice_index_i,
  // cell output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               cell_kind_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_a_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_b_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_c_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_d_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_e_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_f_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_g_o,
  output logic [cmig_pkg::IDX_W-1:0]         corner_h_o,
  output logic                               last_cell_o
);

  logic [cmig_pkg::SC_W-1:0] slice_count_q;
  logic [cmig_pkg::LC_W-1:0] layer_count_q;

  logic              setup_v, setup_rdy;
  cmig_pkg::setup_t  setup_d;
  logic              prod_v, prod_rdy;
  cmig_pkg::prod_t   prod_d;
  logic              col_v, col_rdy;
  cmig_pkg::col_t    col_d;
  cmig_pkg::cell_t   emit_cell;

  // config registers, plain write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= cmig_pkg::SLICE_COUNT_RST;
      layer_count_q <= cmig_pkg::LAYER_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cmig_pkg::CFG_SLICE_COUNT: slice_count_q <= cfg_data_i[cmig_pkg::SC_W-1:0];
        cmig_pkg::CFG_LAYER_COUNT: layer_count_q <= cfg_data_i[cmig_pkg::LC_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: clamp, range check, per-stack vertex count
  cmig_setup #(
    .MAX_STACKS (MAX_STACKS),
    .MAX_SLICES (MAX_SLICES),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_setup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .slice_count_i (slice_count_q),
    .layer_count_i (layer_count_q),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .stack_index_i (stack_index_i),
    .slice_index_i (slice_index_i),
    .valid_o       (setup_v),
    .ready_i       (setup_rdy),
    .data_o        (setup_d)
  );

  // stage 2: stack base and ring offsets
  cmig_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (setup_v),
    .ready_o (setup_rdy),
    .data_i  (setup_d),
    .valid_o (prod_v),
    .ready_i (prod_rdy),
    .data_o  (prod_d)
  );

  // stages 3 and 4: lower then upper corner bases
  cmig_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_v),
    .ready_o (prod_rdy),
    .data_i  (prod_d),
    .valid_o (col_v),
    .ready_i (col_rdy),
    .data_o  (col_d)
  );

  // column register and cell output register, one cell per cycle while the output is ready
  cmig_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (col_v),
    .ready_o (col_rdy),
    .data_i  (col_d),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .cell_o  (emit_cell)
  );

  assign cell_kind_o = emit_cell.kind;
  assign corner_a_o  = emit_cell.ca;
  assign corner_b_o  = emit_cell.cb;
  assign corner_c_o  = emit_cell.cc;
  assign corner_d_o  = emit_cell.cd;
  assign corner_e_o  = emit_cell.ce;
  assign corner_f_o  = emit_cell.cf;
  assign corner_g_o  = emit_cell.cg;
  assign corner_h_o  = emit_cell.ch;
  assign last_cell_o = emit_cell.last;

  // the upper face of a prism is the lower face shifted by one stack
  a_prism_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_kind_o == cmig_pkg::CELL_PRISM) |->
      ((corner_e_o - corner_d_o) == (corner_b_o - corner_a_o)))
    else $error("prism upper face does not match lower face");

  // a hexahedron spans two adjacent layers on both slices
  a_hex_layers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cell_kind_o == cmig_pkg::CELL_HEX) |->
      (corner_b_o == corner_a_o + cmig_pkg::IDX_W'(1)) &&
      (corner_c_o == corner_d_o + cmig_pkg::IDX_W'(1)))
    else $error("hexahedron corners not on adjacent layers");

  // inside a column the next cell follows at once and is a hexahedron
  a_column_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_cell_o |=>
      out_valid_o && (cell_kind_o == cmig_pkg::CELL_HEX))
    else $error("column cells not contiguous");

  // a new column always opens with its prism
  a_column_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_cell_o |=>
      !out_valid_o || (cell_kind_o == cmig_pkg::CELL_PRISM))
    else $error("column does not start with a prism");

endmodule

`default_nettype wire
